### hdl/dnsp_pkg.sv
package dnsp_pkg;

    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  POINTER_MARK = 8'hC0;
    localparam logic [7:0]  RCODE_MASK   = 8'h0F;
    localparam logic [15:0] ADDR_DATA_LEN = 16'h0004;

    // Configuration register indexes.
    localparam logic CFG_WANTED_TYPE  = 1'b0;
    localparam logic CFG_WANTED_CLASS = 1'b1;

    // Result item kinds.
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_SRV_ERROR = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QPTR   = 4'd2,
        PH_QFIXED = 4'd3,
        PH_RNAME  = 4'd4,
        PH_RPTR   = 4'd5,
        PH_RFIXED = 4'd6,
        PH_RDATA  = 4'd7,
        PH_DONE   = 4'd8,
        PH_FAILED = 4'd9
    } t_phase;

    // What one input byte leaves for the output side: a record, a status, or both.
    typedef struct packed {
        logic          has_rec;
        logic          has_stat;
        logic [15:0]   txn_id;
        logic [3:0]    rcode;
        logic [31:0]   address;
        logic [15:0]   record_count;
        t_status       status;
    } t_event;

endpackage

### hdl/dnsp_in_if.sv
interface dnsp_in_if;
    import dnsp_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### hdl/dnsp_out_if.sv
interface dnsp_out_if;
    import dnsp_pkg::*;

    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [15:0] txn_id;
    logic [31:0] address;
    logic [1:0]  status;
    logic [3:0]  rcode;
    logic [15:0] record_count;
    logic        last;

    modport source (output valid, output item_kind, output txn_id, output address,
                    output status, output rcode, output record_count, output last,
                    input ready);
    modport sink   (input valid, input item_kind, input txn_id, input address,
                    input status, input rcode, input record_count, input last,
                    output ready);
endinterface

### hdl/dnsp_front.sv
module dnsp_front
    import dnsp_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    dnsp_in_if.sink       i_in,
    input  logic          i_full,
    output logic          o_push,
    output t_event        o_evt
);

    localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

    logic [15:0]      r_wanted_type,  n_wanted_type;
    logic [15:0]      r_wanted_class, n_wanted_class;

    t_phase           r_phase,   n_phase;
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [3:0]       r_fcnt,    n_fcnt;
    logic [7:0]       r_label,   n_label;
    logic [15:0]      r_id,      n_id;
    logic [3:0]       r_rcode,   n_rcode;
    logic [15:0]      r_qleft,   n_qleft;
    logic [17:0]      r_rleft,   n_rleft;
    logic [15:0]      r_rtype,   n_rtype;
    logic [15:0]      r_rclass,  n_rclass;
    logic [15:0]      r_dlen,    n_dlen;
    logic [31:0]      r_addr,    n_addr;
    logic [15:0]      r_emitted, n_emitted;

    logic             accept;
    logic             hit;
    logic             name_end;
    logic [3:0]       fcnt_inc;
    logic [7:0]       b;
    t_status          stat;

    assign b       = i_in.data_byte;
    assign i_in.ready = !i_full;
    assign accept  = i_in.valid && !i_full;
    assign fcnt_inc = r_fcnt + 4'd1;

    always_comb begin
        n_wanted_type  = r_wanted_type;
        n_wanted_class = r_wanted_class;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WANTED_TYPE:  n_wanted_type  = i_cfg_data;
                CFG_WANTED_CLASS: n_wanted_class = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Byte parser: one byte of the packet per accepted word.
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_fcnt    = r_fcnt;
        n_label   = r_label;
        n_id      = r_id;
        n_rcode   = r_rcode;
        n_qleft   = r_qleft;
        n_rleft   = r_rleft;
        n_rtype   = r_rtype;
        n_rclass  = r_rclass;
        n_dlen    = r_dlen;
        n_addr    = r_addr;
        n_emitted = r_emitted;
        hit       = 1'b0;
        name_end  = 1'b0;
        stat      = ST_OK;

        if (accept && r_pos != POS_MAX) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos < POS_W'(2)) begin
                        n_id = {r_id[7:0], b};
                    end else if (r_pos == POS_W'(3)) begin
                        n_rcode = b[3:0] & RCODE_MASK[3:0];
                    end else if (r_pos == POS_W'(4)) begin
                        n_qleft = {b, 8'h00};
                    end else if (r_pos == POS_W'(5)) begin
                        n_qleft = {r_qleft[15:8], b};
                    end else if (r_pos >= POS_W'(6) && !r_pos[0]) begin
                        n_dlen = {8'h00, b};
                    end else if (r_pos >= POS_W'(7)) begin
                        n_rleft = r_rleft + {2'b00, r_dlen[7:0], b};
                    end
                    if (r_pos == POS_W'(HEADER_BYTES - 1)) begin
                        n_dlen  = '0;
                        n_label = '0;
                        if (r_rcode != 4'd0) begin
                            n_phase = PH_FAILED;
                        end else if (r_qleft != 16'd0) begin
                            n_phase = PH_QNAME;
                        end else begin
                            n_phase = (n_rleft != 18'd0) ? PH_RNAME : PH_DONE;
                        end
                    end
                end
                PH_QNAME, PH_RNAME: begin
                    if (r_label != 8'd0) begin
                        n_label = r_label - 8'd1;
                    end else if (b == 8'd0) begin
                        name_end = 1'b1;
                    end else if ((b & POINTER_MARK) == POINTER_MARK) begin
                        // A compression pointer ends the name after one more byte.
                        n_phase = (r_phase == PH_QNAME) ? PH_QPTR : PH_RPTR;
                    end else begin
                        n_label = b;
                    end
                    if (name_end) begin
                        n_phase = (r_phase == PH_QNAME) ? PH_QFIXED : PH_RFIXED;
                        n_fcnt  = '0;
                    end
                end
                PH_QPTR: begin
                    n_phase = PH_QFIXED;
                    n_fcnt  = '0;
                end
                PH_RPTR: begin
                    n_phase = PH_RFIXED;
                    n_fcnt  = '0;
                end
                PH_QFIXED: begin
                    n_fcnt = fcnt_inc;
                    if (fcnt_inc >= 4'd4) begin
                        n_qleft = r_qleft - 16'd1;
                        n_label = '0;
                        if (n_qleft != 16'd0) begin
                            n_phase = PH_QNAME;
                        end else begin
                            n_phase = (r_rleft != 18'd0) ? PH_RNAME : PH_DONE;
                        end
                    end
                end
                PH_RFIXED: begin
                    if (r_fcnt < 4'd2) begin
                        n_rtype = {r_rtype[7:0], b};
                    end else if (r_fcnt < 4'd4) begin
                        n_rclass = {r_rclass[7:0], b};
                    end else if (r_fcnt >= 4'd8) begin
                        n_dlen = {r_dlen[7:0], b};
                    end
                    n_fcnt = fcnt_inc;
                    if (fcnt_inc >= 4'd10) begin
                        n_addr = '0;
                        // The field counter holds the match flag while data bytes pass.
                        n_fcnt = {3'b000, (n_rtype == r_wanted_type) &&
                                  (n_rclass == r_wanted_class) && (n_dlen == ADDR_DATA_LEN)};
                        if (n_dlen == 16'd0) begin
                            n_rleft = r_rleft - 18'd1;
                            n_label = '0;
                            n_phase = (n_rleft != 18'd0) ? PH_RNAME : PH_DONE;
                        end else begin
                            n_phase = PH_RDATA;
                        end
                    end
                end
                PH_RDATA: begin
                    n_addr = {r_addr[23:0], b};
                    n_dlen = r_dlen - 16'd1;
                    if (n_dlen == 16'd0) begin
                        hit     = (r_fcnt != 4'd0);
                        n_rleft = r_rleft - 18'd1;
                        n_label = '0;
                        n_phase = (n_rleft != 18'd0) ? PH_RNAME : PH_DONE;
                    end
                end
                default: ;
            endcase
            if (hit && r_emitted != 16'hFFFF) begin
                n_emitted = r_emitted + 16'd1;
            end
            n_pos = r_pos + POS_W'(1);
        end

        if (n_pos < POS_W'(HEADER_BYTES)) begin
            stat = ST_SHORT;
        end else if (n_rcode != 4'd0) begin
            stat = ST_SRV_ERROR;
        end else if (n_phase != PH_DONE) begin
            stat = ST_TRUNCATED;
        end

        o_evt.has_rec        = hit;
        o_evt.has_stat       = i_in.last_byte;
        o_evt.txn_id         = n_id;
        o_evt.rcode          = n_rcode;
        o_evt.address        = n_addr;
        o_evt.record_count   = n_emitted;
        o_evt.status         = stat;
        o_push = accept && (hit || i_in.last_byte);

        if (accept && i_in.last_byte) begin
            n_phase   = PH_HEADER;
            n_pos     = '0;
            n_fcnt    = '0;
            n_label   = '0;
            n_id      = '0;
            n_rcode   = '0;
            n_qleft   = '0;
            n_rleft   = '0;
            n_rtype   = '0;
            n_rclass  = '0;
            n_dlen    = '0;
            n_addr    = '0;
            n_emitted = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_type  <= 16'd1;
            r_wanted_class <= 16'd1;
            r_phase   <= PH_HEADER;
            r_pos     <= '0;
            r_fcnt    <= '0;
            r_label   <= '0;
            r_id      <= '0;
            r_rcode   <= '0;
            r_qleft   <= '0;
            r_rleft   <= '0;
            r_rtype   <= '0;
            r_rclass  <= '0;
            r_dlen    <= '0;
            r_addr    <= '0;
            r_emitted <= '0;
        end else begin
            r_wanted_type  <= n_wanted_type;
            r_wanted_class <= n_wanted_class;
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_fcnt    <= n_fcnt;
            r_label   <= n_label;
            r_id      <= n_id;
            r_rcode   <= n_rcode;
            r_qleft   <= n_qleft;
            r_rleft   <= n_rleft;
            r_rtype   <= n_rtype;
            r_rclass  <= n_rclass;
            r_dlen    <= n_dlen;
            r_addr    <= n_addr;
            r_emitted <= n_emitted;
        end
    end

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX) else $error("byte position passed the packet limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last_byte |=> r_pos == '0 && r_emitted == 16'd0)
        else $error("parse state not cleared after the last byte");

    a_hit_only_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> r_phase == PH_RDATA && r_dlen == 16'd1)
        else $error("record emitted outside its final data byte");

endmodule

### hdl/dnsp_queue.sv
module dnsp_queue
    import dnsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_evt,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_event o_evt
);

    t_event            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_evt   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = i_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr  = do_pop ? r_rptr + QPTR_W'(1) : r_rptr;
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !do_pop |=> r_count == $past(r_count) + QCNT_W'(1))
        else $error("queue count did not follow a push");

endmodule

### hdl/dnsp_back.sv
module dnsp_back
    import dnsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_event    i_evt,
    output logic      o_pop,
    dnsp_out_if.source o_out
);

    t_event r_evt;
    logic   r_busy,     n_busy;
    logic   r_rec_sent, n_rec_sent;
    logic   rec_word;
    logic   fire;
    logic   evt_end;

    // A record word goes out first when a byte carries both a record and a status.
    assign rec_word = r_evt.has_rec && !r_rec_sent;
    assign fire     = r_busy && o_out.ready;
    assign evt_end  = fire && (!rec_word || !r_evt.has_stat);
    assign o_pop    = i_valid && (!r_busy || evt_end);

    always_comb begin
        n_busy     = r_busy;
        n_rec_sent = r_rec_sent;
        if (o_pop) begin
            n_busy     = 1'b1;
            n_rec_sent = 1'b0;
        end else if (evt_end) begin
            n_busy = 1'b0;
        end else if (fire) begin
            n_rec_sent = 1'b1;
        end
    end

    always_comb begin
        o_out.valid          = r_busy;
        o_out.txn_id         = r_evt.txn_id;
        o_out.rcode          = r_evt.rcode;
        o_out.record_count   = r_evt.record_count;
        if (rec_word) begin
            o_out.item_kind = KIND_RECORD;
            o_out.address   = r_evt.address;
            o_out.status    = ST_OK;
            o_out.last      = !r_evt.has_stat;
        end else begin
            o_out.item_kind = KIND_STATUS;
            o_out.address   = '0;
            o_out.status    = r_evt.status;
            o_out.last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_evt <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_rec_sent <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_rec_sent <= n_rec_sent;
        end
    end

    a_record_then_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && rec_word && r_evt.has_stat |=> o_out.valid && o_out.item_kind == KIND_STATUS)
        else $error("status word did not follow its record word");

    a_record_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.item_kind == KIND_RECORD |-> o_out.status == ST_OK)
        else $error("record word with a nonzero status");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.item_kind == KIND_STATUS |-> o_out.last)
        else $error("status word not marked last");

endmodule

### hdl/dns_response_record_parser_top.sv
// DNS response record parser.
// Input channel i_in carries one packet byte per word (data_byte, last_byte marking the
// final byte). Output channel o_out carries result words: an address record for every
// resource record whose type and class equal the configured values and whose data is
// four bytes long, and one status word on the last byte of each packet. When the last
// byte also completes a record, the record word comes first and the status word second;
// the field last is set on the final word caused by a byte.
// The configuration port writes wanted_type (index 0) and wanted_class (index 1), both
// 1 after reset; it must be written only while no packet is in flight; the block
// does not enforce this. One byte is accepted per cycle while the queue is not full.
// The parser writes the event of a byte into a four-entry event queue, from which it is
// loaded into the output register, which a two-word byte holds until both are taken.
// When the receiver stalls, the queue fills and i_in.ready drops once it is full.
// Reset clears the parse state, the queue and the output stage; the parser returns to
// the header phase by itself after every last byte.
module dns_response_record_parser_top
    import dnsp_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    dnsp_in_if.sink     i_in,
    dnsp_out_if.source  o_out
);

    logic   front_push;
    t_event front_evt;
    logic   queue_full;
    logic   queue_valid;
    t_event queue_evt;
    logic   back_pop;

    dnsp_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (queue_full),
        .o_push     (front_push),
        .o_evt      (front_evt)
    );

    dnsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_evt   (front_evt),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_evt   (queue_evt)
    );

    dnsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_evt   (queue_evt),
        .o_pop   (back_pop),
        .o_out   (o_out)
    );

endmodule

### tb/sv/dns_response_record_parser_top_test.sv
module dns_response_record_parser_top_test;
    import dnsp_pkg::*;

    localparam int unsigned PKT_LIMIT    = 65536;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned PHASE_BYTES  = 420;
    localparam int unsigned TAIL_BYTES   = 40;

    typedef struct packed {
        logic        kind;
        logic [15:0] tid;
        logic [31:0] addr;
        t_status     status;
        logic [3:0]  rcode;
        logic [15:0] count;
        logic        last;
    } t_dns_word;

    typedef struct packed {
        logic [7:0] data;
        logic       lb;
        logic       typed;
        t_dns_word  word;
    } t_dir_row;

    typedef enum logic [1:0] {
        PK_CLEAN,
        PK_RCODE,
        PK_CUT,
        PK_NOISE
    } t_pkt_form;

    localparam t_dns_word NO_WORD = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    dnsp_in_if  in_ch ();
    dnsp_out_if out_ch ();

    dns_response_record_parser_top #(
        .MAX_PACKET_BYTES(PKT_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Filter settings and running parse state as the block should hold them.
    logic [15:0] want_type;
    logic [15:0] want_class;
    t_phase      m_phase;
    int unsigned m_pos;
    logic [3:0]  m_fcnt;
    logic [7:0]  m_lab;
    logic [15:0] m_hid;
    logic [3:0]  m_rcode;
    logic [15:0] m_qleft;
    logic [17:0] m_rleft;
    logic [15:0] m_rtype;
    logic [15:0] m_rclass;
    logic [15:0] m_dlen;
    logic [31:0] m_addr;
    logic [15:0] m_emit;

    t_dns_word   dns_words_due[$];
    int unsigned fail_count = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    bit          hold_req = 1'b0;
    logic [7:0]  pkt[$];

    t_dir_row dir_tab [31] = '{
        // Short header: only the id bytes arrive.
        '{8'h12, 1'b0, 1'b0, NO_WORD},
        '{8'h34, 1'b1, 1'b1, '{KIND_STATUS, 16'h1234, 32'h0, ST_SHORT, 4'h0, 16'h0, 1'b1}},
        '{8'h00, 1'b1, 1'b1, '{KIND_STATUS, 16'h0000, 32'h0, ST_SHORT, 4'h0, 16'h0, 1'b1}},
        // One answer whose name is a compression pointer; its last data byte ends the packet.
        '{8'hFF, 1'b0, 1'b0, NO_WORD}, '{8'hFF, 1'b0, 1'b0, NO_WORD},
        '{8'h81, 1'b0, 1'b0, NO_WORD}, '{8'h80, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD}, '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD}, '{8'h01, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD}, '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD}, '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'hC0, 1'b0, 1'b0, NO_WORD}, '{8'h0C, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD}, '{8'h01, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD}, '{8'h01, 1'b0, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, 1'b0, NO_WORD}, '{8'hFF, 1'b0, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, 1'b0, NO_WORD}, '{8'hFF, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD}, '{8'h04, 1'b0, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, 1'b0, NO_WORD}, '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h80, 1'b0, 1'b0, NO_WORD}, '{8'h01, 1'b1, 1'b0, NO_WORD}
    };

    function automatic logic [7:0] rnd8();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic void put_byte(input logic [7:0] v);
        pkt.insert(pkt.size(), v);
    endfunction

    function automatic void due_word(input t_dns_word w);
        dns_words_due.insert(dns_words_due.size(), w);
    endfunction

    function automatic void clear_packet();
        m_phase  = PH_HEADER;
        m_pos    = 0;
        m_fcnt   = '0;
        m_lab    = '0;
        m_hid    = '0;
        m_rcode  = '0;
        m_qleft  = '0;
        m_rleft  = '0;
        m_rtype  = '0;
        m_rclass = '0;
        m_dlen   = '0;
        m_addr   = '0;
        m_emit   = '0;
    endfunction

    function automatic void start_records();
        m_lab   = '0;
        m_phase = (m_rleft != '0) ? PH_RNAME : PH_DONE;
    endfunction

    function automatic void record_done();
        m_rleft = m_rleft - 18'd1;
        start_records();
    endfunction

    // One byte of a name; returns 1 when the terminating zero has been seen.
    function automatic logic name_step(input logic [7:0] b, input t_phase ptr_ph);
        if (m_lab != '0) begin
            m_lab = m_lab - 8'd1;
            return 1'b0;
        end
        if (b == 8'h00) return 1'b1;
        if ((b & POINTER_MARK) == POINTER_MARK) m_phase = ptr_ph;
        else m_lab = b;
        return 1'b0;
    endfunction

    function automatic t_dns_word form_word(input logic kind, input logic [31:0] addr,
                                            input t_status st, input logic last);
        t_dns_word w;
        w.kind   = kind;
        w.tid    = m_hid;
        w.addr   = addr;
        w.status = st;
        w.rcode  = m_rcode;
        w.count  = m_emit;
        w.last   = last;
        return w;
    endfunction

    task automatic parse_dns_byte(input logic [7:0] b, input logic lb);
        logic       hit;
        logic [7:0] masked;
        t_status    st;
        hit = 1'b0;
        if (m_pos < PKT_LIMIT) begin
            case (m_phase)
                PH_HEADER: begin
                    masked = b & RCODE_MASK;
                    if (m_pos < 2) m_hid = {m_hid[7:0], b};
                    else if (m_pos == 3) m_rcode = masked[3:0];
                    else if (m_pos == 4) m_qleft = {b, 8'h00};
                    else if (m_pos == 5) m_qleft[7:0] = b;
                    else if (m_pos >= 6 && m_pos[0] == 1'b0) m_dlen = {8'h00, b};
                    else if (m_pos >= 7) m_rleft = m_rleft + {2'b00, m_dlen[7:0], b};
                    if (m_pos == HEADER_BYTES - 1) begin
                        m_dlen = '0;
                        m_lab  = '0;
                        if (m_rcode != '0) m_phase = PH_FAILED;
                        else if (m_qleft != '0) m_phase = PH_QNAME;
                        else start_records();
                    end
                end
                PH_QNAME, PH_QPTR: begin
                    if (m_phase == PH_QPTR || name_step(b, PH_QPTR)) begin
                        m_phase = PH_QFIXED;
                        m_fcnt  = '0;
                    end
                end
                PH_QFIXED: begin
                    m_fcnt = m_fcnt + 4'd1;
                    if (m_fcnt >= 4) begin
                        m_qleft = m_qleft - 16'd1;
                        m_lab   = '0;
                        if (m_qleft != '0) m_phase = PH_QNAME;
                        else start_records();
                    end
                end
                PH_RNAME, PH_RPTR: begin
                    if (m_phase == PH_RPTR || name_step(b, PH_RPTR)) begin
                        m_phase = PH_RFIXED;
                        m_fcnt  = '0;
                    end
                end
                PH_RFIXED: begin
                    if (m_fcnt < 2) m_rtype = {m_rtype[7:0], b};
                    else if (m_fcnt < 4) m_rclass = {m_rclass[7:0], b};
                    else if (m_fcnt >= 8) m_dlen = {m_dlen[7:0], b};
                    m_fcnt = m_fcnt + 4'd1;
                    if (m_fcnt >= 10) begin
                        m_addr = '0;
                        // From here on the counter only flags whether the record matches.
                        m_fcnt = (m_rtype == want_type && m_rclass == want_class &&
                                  m_dlen == ADDR_DATA_LEN) ? 4'd1 : 4'd0;
                        if (m_dlen == '0) record_done();
                        else m_phase = PH_RDATA;
                    end
                end
                PH_RDATA: begin
                    m_addr = {m_addr[23:0], b};
                    m_dlen = m_dlen - 16'd1;
                    if (m_dlen == '0) begin
                        hit = (m_fcnt != '0);
                        record_done();
                    end
                end
                default: ;
            endcase
            m_pos++;
        end
        if (hit) begin
            if (m_emit != 16'hFFFF) m_emit = m_emit + 16'd1;
            due_word(form_word(KIND_RECORD, m_addr, ST_OK, !lb));
        end
        if (lb) begin
            if (m_pos < HEADER_BYTES) st = ST_SHORT;
            else if (m_rcode != '0) st = ST_SRV_ERROR;
            else if (m_phase != PH_DONE) st = ST_TRUNCATED;
            else st = ST_OK;
            due_word(form_word(KIND_STATUS, 32'h0, st, 1'b1));
            clear_packet();
        end
    endtask

    // Offers one word and returns right after the edge that takes it.
    task automatic push_byte(input logic [7:0] b, input logic lb, input logic typed,
                             input t_dns_word tw);
        int n0;
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= lb;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        n0 = dns_words_due.size();
        parse_dns_byte(b, lb);
        if (typed) begin
            while (dns_words_due.size() > n0) void'(dns_words_due.pop_back());
            due_word(tw);
        end
    endtask

    task automatic send_packet();
        foreach (pkt[i]) push_byte(pkt[i], i == pkt.size() - 1, 1'b0, NO_WORD);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (dns_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_filter(input logic idx, input logic [15:0] val);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WANTED_TYPE) want_type = val;
        else want_class = val;
    endtask

    function automatic logic [15:0] pick_filter();
        case ($urandom_range(3))
            0: return 16'h0001;
            1: return 16'h0000;
            2: return 16'hFFFF;
            default: return {rnd8(), rnd8()};
        endcase
    endfunction

    task automatic add_name();
        int unsigned len;
        repeat ($urandom_range(2)) begin
            // Now and then a label length in the 0x40..0xBF range, taken as plain length.
            if ($urandom_range(39) == 0) len = $urandom_range(8'hBF, 8'h40);
            else len = $urandom_range(5, 1);
            put_byte(len[7:0]);
            repeat (len) put_byte(rnd8());
        end
        if ($urandom_range(2) == 0) begin
            put_byte(POINTER_MARK | (rnd8() & 8'h3F));
            put_byte(rnd8());
        end else begin
            put_byte(8'h00);
        end
    endtask

    task automatic add_record();
        logic [15:0] ty;
        logic [15:0] cl;
        logic [15:0] rl;
        add_name();
        ty = ($urandom_range(9) < 7) ? want_type : {rnd8(), rnd8()};
        cl = ($urandom_range(9) < 8) ? want_class : {rnd8(), rnd8()};
        case ($urandom_range(9))
            0: rl = 16'd0;
            1: rl = 16'($urandom_range(8, 1));
            default: rl = ADDR_DATA_LEN;
        endcase
        put_byte(ty[15:8]);
        put_byte(ty[7:0]);
        put_byte(cl[15:8]);
        put_byte(cl[7:0]);
        repeat (4) put_byte(rnd8());
        put_byte(rl[15:8]);
        put_byte(rl[7:0]);
        repeat (rl) put_byte(rnd8());
    endtask

    task automatic build_packet(input t_pkt_form form);
        logic [15:0] qd;
        logic [15:0] nrec [3];
        logic [3:0]  rc;
        int unsigned keep;
        pkt.delete();
        if (form == PK_NOISE) begin
            repeat ($urandom_range(30, 1)) put_byte(rnd8());
            return;
        end
        qd      = 16'($urandom_range(2));
        nrec[0] = 16'($urandom_range(3));
        nrec[1] = 16'($urandom_range(1));
        nrec[2] = 16'($urandom_range(1));
        rc      = (form == PK_RCODE) ? 4'($urandom_range(15, 1)) : 4'h0;
        put_byte(rnd8());
        put_byte(rnd8());
        put_byte(rnd8());
        put_byte((rnd8() & 8'hF0) | {4'h0, rc});
        put_byte(qd[15:8]);
        put_byte(qd[7:0]);
        foreach (nrec[k]) begin
            put_byte(nrec[k][15:8]);
            put_byte(nrec[k][7:0]);
        end
        repeat (qd) begin
            add_name();
            repeat (4) put_byte(rnd8());
        end
        repeat (nrec[0] + nrec[1] + nrec[2]) add_record();
        if ($urandom_range(4) == 0) repeat ($urandom_range(4, 1)) put_byte(rnd8());
        if (form == PK_CUT) begin
            keep = $urandom_range(pkt.size() - 1, 1);
            while (pkt.size() > keep) void'(pkt.pop_back());
        end
    endtask

    initial begin : result_side
        t_dns_word   got;
        t_dns_word   want;
        int unsigned hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.kind   = out_ch.item_kind;
                got.tid    = out_ch.txn_id;
                got.addr   = out_ch.address;
                got.status = t_status'(out_ch.status);
                got.rcode  = out_ch.rcode;
                got.count  = out_ch.record_count;
                got.last   = out_ch.last;
                if (dns_words_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: word with nothing due: kind=%0d id=%h addr=%h st=%0d",
                                 $realtime, got.kind, got.tid, got.addr, got.status);
                    fail_count++;
                end else begin
                    want = dns_words_due.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) begin
                            $display({"%0t: expected kind=%0d id=%h addr=%h st=%0d",
                                      " rc=%h cnt=%0d last=%0d"},
                                     $realtime, want.kind, want.tid, want.addr, want.status,
                                     want.rcode, want.count, want.last);
                            $display({"%0t:   actual kind=%0d id=%h addr=%h st=%0d",
                                      " rc=%h cnt=%0d last=%0d"},
                                     $realtime, got.kind, got.tid, got.addr, got.status,
                                     got.rcode, got.count, got.last);
                        end
                        fail_count++;
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    initial begin : byte_side
        int unsigned phase_bytes;
        int unsigned pick;
        t_pkt_form   form;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_WANTED_TYPE;
        i_cfg_data      <= 16'h0000;
        want_type  = 16'h0001;
        want_class = 16'h0001;
        clear_packet();
        send_gap_pct = 12;
        recv_gap_pct = 75;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            push_byte(dir_tab[i].data, dir_tab[i].lb, dir_tab[i].typed, dir_tab[i].word);

        for (int ph = 0; ph < 3; ph++) begin
            send_gap_pct = (ph == 0) ? 12 : (ph == 1) ? 75 : 0;
            recv_gap_pct = (ph == 0) ? 75 : (ph == 1) ? 12 : 0;
            if (ph == 1) begin
                set_filter(CFG_WANTED_TYPE, 16'hFFFF);
                set_filter(CFG_WANTED_CLASS, 16'h0000);
            end else if (ph == 2) begin
                set_filter(CFG_WANTED_TYPE, 16'h0000);
                set_filter(CFG_WANTED_CLASS, 16'hFFFF);
            end
            // The receiver holds off while one-byte packets keep coming, so the queue fills.
            hold_req = 1'b1;
            repeat (12) begin
                pkt.delete();
                put_byte(rnd8());
                send_packet();
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                if ($urandom_range(99) < 8) begin
                    set_filter(CFG_WANTED_TYPE, pick_filter());
                    set_filter(CFG_WANTED_CLASS, pick_filter());
                end
                pick = $urandom_range(9);
                if (pick < 6) form = PK_CLEAN;
                else if (pick == 6) form = PK_RCODE;
                else if (pick < 9) form = PK_CUT;
                else form = PK_NOISE;
                build_packet(form);
                phase_bytes += pkt.size();
                send_packet();
            end
        end

        // A packet whose record counts cannot be met ends truncated.
        pkt.delete();
        put_byte(rnd8());
        put_byte(rnd8());
        put_byte(8'h01);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h00);
        repeat (6) put_byte(8'hFF);
        while (pkt.size() < TAIL_BYTES) put_byte(rnd8());
        send_packet();

        wait_drained();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
